### src/mdhgr_pkg.sv
// ----------------------------------------------------------------------------
// mdhgr_pkg
// types, constants and helper functions shared by the drum report cell chain
// ----------------------------------------------------------------------------
package mdhgr_pkg;

  localparam int NUM_TARGETS = 9;
  localparam int TGT_W       = 4;
  localparam int VEL_W       = 7;
  localparam int BTN_W       = 13;
  localparam int HAT_W       = 4;
  localparam int HOLD_W      = 16;
  localparam int NOTE_W      = 7;
  localparam int STAMP_W     = 32;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 48;

  localparam logic [TGT_W-1:0] TGT_RED_PAD = 4'd0;
  localparam logic [TGT_W-1:0] TGT_YEL_PAD = 4'd1;
  localparam logic [TGT_W-1:0] TGT_BLU_PAD = 4'd2;
  localparam logic [TGT_W-1:0] TGT_GRN_PAD = 4'd3;
  localparam logic [TGT_W-1:0] TGT_YEL_CYM = 4'd4;
  localparam logic [TGT_W-1:0] TGT_BLU_CYM = 4'd5;
  localparam logic [TGT_W-1:0] TGT_GRN_CYM = 4'd6;
  localparam logic [TGT_W-1:0] TGT_KICK    = 4'd7;
  localparam logic [TGT_W-1:0] TGT_HIHAT   = 4'd8;
  localparam logic [TGT_W-1:0] TGT_NONE    = 4'd15;

  localparam int BTN_BLUE   = 0;
  localparam int BTN_GREEN  = 1;
  localparam int BTN_RED    = 2;
  localparam int BTN_YELLOW = 3;
  localparam int BTN_KICK   = 4;
  localparam int BTN_HIHAT  = 5;
  localparam int BTN_GBLUE  = 6;
  localparam int BTN_GGREEN = 7;
  localparam int BTN_PADHIT = 10;
  localparam int BTN_CYMHIT = 11;

  localparam logic [HAT_W-1:0] HAT_UP     = 4'd0;
  localparam logic [HAT_W-1:0] HAT_SOUTH  = 4'd4;
  localparam logic [HAT_W-1:0] HAT_CENTER = 4'd8;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd20;

  localparam logic [CFG_IDX_W-1:0] CFG_GENERIC_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS      = 4'd1;

  localparam logic CMD_NOTE_ON = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef enum logic {
    OP_SCAN,
    OP_TICK
  } sweep_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_TICK,
    ST_DONE
  } state_e;

  // request travelling down the cell chain
  typedef struct packed {
    logic             valid;
    sweep_op_e        op;
    logic             found;
    logic [TGT_W-1:0] min_idx;
    logic             event_seen;
    logic [BTN_W-1:0] btn;
    logic [HAT_W-1:0] hat;
    logic [VEL_W-1:0] vy;
    logic [VEL_W-1:0] vr;
    logic [VEL_W-1:0] vg;
    logic [VEL_W-1:0] vb;
  } sweep_t;

  // broadcast write or clear of one cell
  typedef struct packed {
    logic             wr;
    logic             clr;
    logic [TGT_W-1:0] sel;
    logic [VEL_W-1:0] vel;
  } cell_cmd_t;

  function automatic logic [TGT_W-1:0] note_to_target(logic [NOTE_W-1:0] n);
    logic [TGT_W-1:0] t;
    case (n)
      7'd31, 7'd34, 7'd37, 7'd38, 7'd39, 7'd40: t = TGT_RED_PAD;
      7'd48, 7'd50:                             t = TGT_YEL_PAD;
      7'd45, 7'd47:                             t = TGT_BLU_PAD;
      7'd41, 7'd43:                             t = TGT_GRN_PAD;
      7'd22, 7'd26, 7'd42, 7'd46, 7'd54:        t = TGT_YEL_CYM;
      7'd51, 7'd53, 7'd56, 7'd59:               t = TGT_BLU_CYM;
      7'd49, 7'd52, 7'd55, 7'd57:               t = TGT_GRN_CYM;
      7'd33, 7'd35, 7'd36:                      t = TGT_KICK;
      7'd44:                                    t = TGT_HIHAT;
      default:                                  t = TGT_NONE;
    endcase
    return t;
  endfunction

  function automatic logic is_pad(logic [TGT_W-1:0] t);
    return t <= TGT_GRN_PAD;
  endfunction

  function automatic logic is_cym(logic [TGT_W-1:0] t);
    return (t >= TGT_YEL_CYM) && (t <= TGT_GRN_CYM);
  endfunction

  // pad/cymbal mix rule for a new hit on target t
  function automatic logic mix_conflict(logic [NUM_TARGETS-1:0] act, logic [TGT_W-1:0] t);
    logic [2:0] pads;
    logic [1:0] cyms;
    logic       c;
    pads = 3'(act[0]) + 3'(act[1]) + 3'(act[2]) + 3'(act[3]);
    cyms = 2'(act[4]) + 2'(act[5]) + 2'(act[6]);
    if (is_pad(t)) begin
      c = !((cyms == 2'd0) || ((pads == 3'd0) && (cyms == 2'd1)));
    end else if (is_cym(t)) begin
      c = !((pads == 3'd0) || ((cyms == 2'd0) && (pads == 3'd1)));
    end else begin
      c = 1'b0;
    end
    return c;
  endfunction

  // add one held hit to the report under construction
  function automatic sweep_t tick_add(sweep_t p, logic [TGT_W-1:0] idx,
                                      logic [VEL_W-1:0] v, logic gen);
    sweep_t r;
    r = p;
    case (idx)
      TGT_RED_PAD: begin
        r.btn[BTN_RED] = 1'b1;
        r.vr = v;
      end
      TGT_YEL_PAD: begin
        r.btn[BTN_YELLOW] = 1'b1;
        r.vy = v;
      end
      TGT_BLU_PAD: begin
        r.btn[BTN_BLUE] = 1'b1;
        r.vb = v;
      end
      TGT_GRN_PAD: begin
        r.btn[BTN_GREEN] = 1'b1;
        r.vg = v;
      end
      TGT_YEL_CYM: begin
        if (gen) begin
          r.btn[BTN_PADHIT] = 1'b1;
        end else begin
          r.btn[BTN_YELLOW] = 1'b1;
          r.hat = HAT_UP;
        end
        if (r.vy == '0) r.vy = v;
        else r.vr = v;
      end
      TGT_BLU_CYM: begin
        if (gen) begin
          r.btn[BTN_GBLUE] = 1'b1;
        end else begin
          r.btn[BTN_BLUE] = 1'b1;
          r.hat = HAT_SOUTH;
        end
        if (r.vb == '0) r.vb = v;
        else r.vr = v;
      end
      TGT_GRN_CYM: begin
        if (gen) r.btn[BTN_GGREEN] = 1'b1;
        else r.btn[BTN_GREEN] = 1'b1;
        if (r.vg == '0) r.vg = v;
        else r.vr = v;
      end
      TGT_KICK: begin
        r.btn[BTN_KICK] = 1'b1;
      end
      default: begin
        r.btn[BTN_HIHAT] = 1'b1;
      end
    endcase
    if (!gen) begin
      if (is_pad(idx)) r.btn[BTN_PADHIT] = 1'b1;
      else if (is_cym(idx)) r.btn[BTN_CYMHIT] = 1'b1;
    end
    return r;
  endfunction

endpackage

### src/midi_drum_hit_to_gamepad_report.sv
// ----------------------------------------------------------------------------
// midi_drum_hit_to_gamepad_report
// maps drum note-on requests to nine held targets and builds gamepad reports
//
//   channel   dir  handshake                    contents
//   s_axis    in   s_axis_tvalid/tready         note-on or report tick
//   m_axis    out  m_axis_tvalid/tready         report: buttons, hat, velocities
//   cfg       in   cfg_valid_i/cfg_ready_o      register index and data
//
// a report tick passes the launch register, then each cell stage of the
// nine-cell chain in turn, then the final capture and the output load
// a note-on is checked, then written; each eviction scan walks the chain first
// reset clears all hits, layout generic, hold 20 ms, hat centered
// input ready is low while a request is in work; a stalled report holds
// the final stage until the output register frees
// ----------------------------------------------------------------------------
module midi_drum_hit_to_gamepad_report import mdhgr_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // note[6:0], velocity[13:7], now_ms[45:14], host_ready[46], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // buttons[12:0], hat[16:13], vel_yellow[23:17], vel_red[30:24],
  // vel_green[37:31], vel_blue[44:38], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e               state_q, state_d;
  sweep_t               launch_q, launch_d;
  sweep_t               fin_q, fin_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [TGT_W-1:0]     tgt_q, tgt_d;
  logic [VEL_W-1:0]     vel_q, vel_d;
  logic                 generic_q;
  logic [HOLD_W-1:0]    hold_q;
  logic [BTN_W-1:0]     held_btn_q, held_btn_d;
  logic [HAT_W-1:0]     held_hat_q, held_hat_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  cell_cmd_t            cmd;

  sweep_t               link [NUM_TARGETS+1];
  logic [TIME_BITS-1:0] link_min [NUM_TARGETS+1];
  logic [NUM_TARGETS-1:0] active_vec;
  sweep_t               tail;
  logic                 in_req;

  assign link[0]     = launch_q;
  assign link_min[0] = '0;
  assign tail        = link[NUM_TARGETS];

  for (genvar g = 0; g < NUM_TARGETS; g++) begin : g_cell
    mdhgr_cell #(
      .IDX       (g),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .pkt_i      (link[g]),
      .min_time_i (link_min[g]),
      .cmd_i      (cmd),
      .now_i      (now_q),
      .hold_i     (hold_q),
      .generic_i  (generic_q),
      .pkt_o      (link[g+1]),
      .min_time_o (link_min[g+1]),
      .active_o   (active_vec[g])
    );
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d     = state_q;
    launch_d    = '0;
    fin_d       = fin_q;
    now_d       = now_q;
    tgt_d       = tgt_q;
    vel_d       = vel_q;
    held_btn_d  = held_btn_q;
    held_hat_d  = held_hat_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    cmd         = '0;
    if (m_axis_tvalid && m_axis_tready) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          now_d = s_axis_tdata[14 +: TIME_BITS];
          if (s_axis_tuser == CMD_NOTE_ON) begin
            tgt_d   = note_to_target(s_axis_tdata[6:0]);
            vel_d   = s_axis_tdata[13:7];
            state_d = ST_CHECK;
          end else if (s_axis_tdata[46]) begin
            launch_d.valid = 1'b1;
            launch_d.op    = OP_TICK;
            launch_d.hat   = HAT_CENTER;
            state_d        = ST_TICK;
          end
        end
      end
      ST_CHECK: begin
        if (tgt_q == TGT_NONE) begin
          state_d = ST_IDLE;
        end else if (active_vec[tgt_q]) begin
          state_d = ST_IDLE;
        end else if (mix_conflict(active_vec, tgt_q)) begin
          launch_d.valid = 1'b1;
          launch_d.op    = OP_SCAN;
          launch_d.hat   = HAT_CENTER;
          state_d        = ST_SCAN;
        end else begin
          cmd.wr  = 1'b1;
          cmd.sel = tgt_q;
          cmd.vel = vel_q;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (tail.valid) begin
          cmd.clr = 1'b1;
          cmd.sel = tail.min_idx;
          state_d = ST_CHECK;
        end
      end
      ST_TICK: begin
        if (tail.valid) begin
          fin_d = tail;
          if (tail.event_seen) begin
            held_btn_d = tail.btn;
            held_hat_d = tail.hat;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, fin_q.vb, fin_q.vg, fin_q.vr, fin_q.vy,
                         held_hat_q, held_btn_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= '0;
      generic_q   <= 1'b1;
      hold_q      <= HOLD_RESET;
      held_btn_q  <= '0;
      held_hat_q  <= HAT_CENTER;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      held_btn_q  <= held_btn_d;
      held_hat_q  <= held_hat_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_GENERIC_MODE) generic_q <= cfg_data_i[0];
        else if (cfg_index_i == CFG_HOLD_MS) hold_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q      <= fin_d;
    now_q      <= now_d;
    tgt_q      <= tgt_d;
    vel_q      <= vel_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_wr_free_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> (!active_vec[cmd.sel] && (cmd.sel != TGT_NONE)))
    else $error("hit written into a held target");

  a_scan_finds_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail.valid && (tail.op == OP_SCAN)) |-> tail.found)
    else $error("eviction scan found no held hit");

  a_single_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q.valid |-> (!tail.valid && ((state_q == ST_SCAN) || (state_q == ST_TICK))))
    else $error("two requests in the cell chain");

  a_clear_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |=> (state_q == ST_CHECK))
    else $error("eviction not followed by a mix check");

endmodule

### src/mdhgr_cell.sv
// ----------------------------------------------------------------------------
// mdhgr_cell
// one drum target: hit state plus one stage of the request chain
// ----------------------------------------------------------------------------
module mdhgr_cell import mdhgr_pkg::*; #(
  parameter int IDX       = 0,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sweep_t               pkt_i,
  input  logic [TIME_BITS-1:0] min_time_i,
  input  cell_cmd_t            cmd_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [HOLD_W-1:0]    hold_i,
  input  logic                 generic_i,
  output sweep_t               pkt_o,
  output logic [TIME_BITS-1:0] min_time_o,
  output logic                 active_o
);

  localparam logic [TGT_W-1:0] MY_IDX = TGT_W'(IDX);

  sweep_t               pkt_q, pkt_d;
  logic [TIME_BITS-1:0] min_q, min_d;
  logic                 active_q, active_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [VEL_W-1:0]     vel_q, vel_d;
  logic [TIME_BITS-1:0] elapsed;

  assign elapsed = now_i - time_q;

  always_comb begin
    pkt_d    = pkt_i;
    min_d    = min_time_i;
    active_d = active_q;
    time_d   = time_q;
    vel_d    = vel_q;
    if (cmd_i.wr && (cmd_i.sel == MY_IDX)) begin
      active_d = 1'b1;
      time_d   = now_i;
      vel_d    = cmd_i.vel;
    end
    if (cmd_i.clr && (cmd_i.sel == MY_IDX)) begin
      active_d = 1'b0;
    end
    if (pkt_i.valid && active_q) begin
      case (pkt_i.op)
        OP_SCAN: begin
          if (!pkt_i.found || (time_q < min_time_i)) begin
            pkt_d.found   = 1'b1;
            pkt_d.min_idx = MY_IDX;
            min_d         = time_q;
          end
        end
        OP_TICK: begin
          pkt_d.event_seen = 1'b1;
          if (elapsed > TIME_BITS'(hold_i)) begin
            active_d = 1'b0;
          end else begin
            pkt_d = tick_add(pkt_d, MY_IDX, vel_q, generic_i);
          end
        end
        default: begin
          pkt_d = pkt_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q    <= '0;
      active_q <= 1'b0;
    end else begin
      pkt_q    <= pkt_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q  <= min_d;
    time_q <= time_d;
    vel_q  <= vel_d;
  end

  assign pkt_o      = pkt_q;
  assign min_time_o = min_q;
  assign active_o   = active_q;

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the drum-hit to gamepad report block against a cycle-free model
//
// note-on and report-tick requests go in on the input stream with random
// gaps; each ready tick must bring one report out. a model of the nine held
// hits predicts every report, which is matched field by field in order.
// directed requests cover unmapped and repeated notes, ignored ticks,
// cymbal colour reuse, console hat, eviction ties and time wrap; random
// phases then run under several layouts and hold times.
// ----------------------------------------------------------------------------
module tb import mdhgr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_CYCLES = 150;

  typedef struct packed {
    logic [BTN_W-1:0] btn;
    logic [HAT_W-1:0] hat;
    logic [VEL_W-1:0] vy;
    logic [VEL_W-1:0] vr;
    logic [VEL_W-1:0] vg;
    logic [VEL_W-1:0] vb;
  } gamepad_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  midi_drum_hit_to_gamepad_report uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // model state
  logic                layout_generic = 1'b1;
  logic [HOLD_W-1:0]   hold_window = HOLD_RESET;
  logic                pad_held [NUM_TARGETS];
  logic [STAMP_W-1:0]  pad_stamp [NUM_TARGETS];
  logic [VEL_W-1:0]    pad_vel [NUM_TARGETS];
  logic [BTN_W-1:0]    latched_btn = '0;
  logic [HAT_W-1:0]    latched_hat = HAT_CENTER;

  gamepad_report_t reports_due [$];
  gamepad_report_t want_report;
  int              fail_cnt = 0;
  int              cycle_count = 0;
  bit              calm = 1'b0;
  int              want_f [6];
  int              got_f [6];
  string           field_name [6] = '{"buttons", "hat", "vel_yellow", "vel_red",
                                      "vel_green", "vel_blue"};
  int              drum_notes [29] = '{31, 34, 37, 38, 39, 40, 48, 50, 45, 47, 41, 43,
                                      22, 26, 42, 46, 54, 51, 53, 56, 59, 49, 52, 55,
                                      57, 33, 35, 36, 44};

  initial begin
    for (int i = 0; i < NUM_TARGETS; i++) begin
      pad_held[i] = 1'b0;
      pad_stamp[i] = '0;
      pad_vel[i] = '0;
    end
  end

  function automatic int drum_target(logic [NOTE_W-1:0] n);
    case (n)
      7'd31, 7'd34, 7'd37, 7'd38, 7'd39, 7'd40: return int'(TGT_RED_PAD);
      7'd48, 7'd50:                             return int'(TGT_YEL_PAD);
      7'd45, 7'd47:                             return int'(TGT_BLU_PAD);
      7'd41, 7'd43:                             return int'(TGT_GRN_PAD);
      7'd22, 7'd26, 7'd42, 7'd46, 7'd54:        return int'(TGT_YEL_CYM);
      7'd51, 7'd53, 7'd56, 7'd59:               return int'(TGT_BLU_CYM);
      7'd49, 7'd52, 7'd55, 7'd57:               return int'(TGT_GRN_CYM);
      7'd33, 7'd35, 7'd36:                      return int'(TGT_KICK);
      7'd44:                                    return int'(TGT_HIHAT);
      default:                                  return -1;
    endcase
  endfunction

  function automatic bit mix_blocked(int t);
    int pads;
    int cyms;
    pads = 0;
    cyms = 0;
    for (int i = 0; i < NUM_TARGETS; i++) begin
      if (pad_held[i] && i <= TGT_GRN_PAD) pads++;
      else if (pad_held[i] && i >= TGT_YEL_CYM && i <= TGT_GRN_CYM) cyms++;
    end
    if (t <= TGT_GRN_PAD) return !(cyms == 0 || (pads == 0 && cyms == 1));
    if (t <= TGT_GRN_CYM) return !(pads == 0 || (cyms == 0 && pads == 1));
    return 1'b0;
  endfunction

  task automatic drop_hit(int i);
    pad_held[i] = 1'b0;
    pad_stamp[i] = '0;
    pad_vel[i] = '0;
  endtask

  task automatic evict_oldest();
    int pick;
    pick = -1;
    for (int i = 0; i < NUM_TARGETS; i++) begin
      if (pad_held[i] && (pick < 0 || pad_stamp[i] < pad_stamp[pick])) pick = i;
    end
    if (pick >= 0) drop_hit(pick);
  endtask

  // advance the model by one accepted request, queue the report it causes
  task automatic drum_model_step(input logic cmd, input logic [NOTE_W-1:0] note,
                                 input logic [VEL_W-1:0] velo, input logic [31:0] now,
                                 input logic hr, output bit took);
    int              t;
    int              g;
    bit              seen;
    logic [31:0]     age;
    logic [VEL_W-1:0] v;
    gamepad_report_t r;
    took = 1'b0;
    if (cmd == CMD_NOTE_ON) begin
      t = drum_target(note);
      if (t < 0) return;
      if (pad_held[t]) return;
      for (g = 0; g < NUM_TARGETS && mix_blocked(t); g++) evict_oldest();
      pad_held[t] = 1'b1;
      pad_stamp[t] = now;
      pad_vel[t] = velo;
      took = 1'b1;
      return;
    end
    if (!hr) return;
    took = 1'b1;
    r = '0;
    r.hat = HAT_CENTER;
    seen = 1'b0;
    for (int n = 0; n < NUM_TARGETS; n++) begin
      if (!pad_held[n]) continue;
      seen = 1'b1;
      age = now - pad_stamp[n];
      if (age > {16'b0, hold_window}) begin
        drop_hit(n);
        continue;
      end
      v = pad_vel[n];
      case (n)
        TGT_RED_PAD: begin
          r.btn[BTN_RED] = 1'b1;
          r.vr = v;
        end
        TGT_YEL_PAD: begin
          r.btn[BTN_YELLOW] = 1'b1;
          r.vy = v;
        end
        TGT_BLU_PAD: begin
          r.btn[BTN_BLUE] = 1'b1;
          r.vb = v;
        end
        TGT_GRN_PAD: begin
          r.btn[BTN_GREEN] = 1'b1;
          r.vg = v;
        end
        TGT_YEL_CYM: begin
          if (layout_generic) begin
            r.btn[BTN_PADHIT] = 1'b1;
          end else begin
            r.btn[BTN_YELLOW] = 1'b1;
            r.hat = HAT_UP;
          end
          if (r.vy == '0) r.vy = v;
          else r.vr = v;
        end
        TGT_BLU_CYM: begin
          if (layout_generic) begin
            r.btn[BTN_GBLUE] = 1'b1;
          end else begin
            r.btn[BTN_BLUE] = 1'b1;
            r.hat = HAT_SOUTH;
          end
          if (r.vb == '0) r.vb = v;
          else r.vr = v;
        end
        TGT_GRN_CYM: begin
          if (layout_generic) r.btn[BTN_GGREEN] = 1'b1;
          else r.btn[BTN_GREEN] = 1'b1;
          if (r.vg == '0) r.vg = v;
          else r.vr = v;
        end
        TGT_KICK: begin
          r.btn[BTN_KICK] = 1'b1;
        end
        default: begin
          r.btn[BTN_HIHAT] = 1'b1;
        end
      endcase
      if (!layout_generic) begin
        if (n <= TGT_GRN_PAD) r.btn[BTN_PADHIT] = 1'b1;
        else if (n <= TGT_GRN_CYM) r.btn[BTN_CYMHIT] = 1'b1;
      end
    end
    if (seen) begin
      latched_btn = r.btn;
      latched_hat = r.hat;
    end
    r.btn = latched_btn;
    r.hat = latched_hat;
    reports_due.push_back(r);
  endtask

  task automatic push_item(input logic cmd, input logic [NOTE_W-1:0] note,
                           input logic [VEL_W-1:0] velo, input logic [31:0] now,
                           input logic hr, output bit took);
    while (!calm && $urandom_range(0, 99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {1'b0, hr, now, velo, note};
    s_axis_tuser  <= cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    drum_model_step(cmd, note, velo, now, hr, took);
  endtask

  // wait for the block to go idle before a register write
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_GENERIC_MODE) layout_generic = val[0];
    else if (idx == CFG_HOLD_MS) hold_window = val;
    @(posedge clk_i);
  endtask

  // report checker and output backpressure
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_f[0] = int'(m_axis_tdata[12:0]);
      got_f[1] = int'(m_axis_tdata[16:13]);
      got_f[2] = int'(m_axis_tdata[23:17]);
      got_f[3] = int'(m_axis_tdata[30:24]);
      got_f[4] = int'(m_axis_tdata[37:31]);
      got_f[5] = int'(m_axis_tdata[44:38]);
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected report, expected none, got %h", $time,
                 m_axis_tdata);
        fail_cnt++;
      end else begin
        want_report = reports_due.pop_front();
        want_f[0] = int'(want_report.btn);
        want_f[1] = int'(want_report.hat);
        want_f[2] = int'(want_report.vy);
        want_f[3] = int'(want_report.vr);
        want_f[4] = int'(want_report.vg);
        want_f[5] = int'(want_report.vb);
        for (int i = 0; i < 6; i++) begin
          if (want_f[i] != got_f[i]) begin
            $display("%0t: %s expected %0d got %0d", $time, field_name[i],
                     want_f[i], got_f[i]);
            fail_cnt++;
          end
        end
      end
    end
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 22);
  end

  task automatic test_reset_state();
    bit took;
    push_item(CMD_TICK, 7'd0, 7'd0, 32'd0, 1'b1, took);
    push_item(CMD_TICK, 7'd127, 7'd127, 32'd5, 1'b0, took);
    push_item(CMD_NOTE_ON, 7'd127, 7'd127, 32'd0, 1'b1, took);
    push_item(CMD_NOTE_ON, 7'd0, 7'd64, 32'd0, 1'b0, took);
    push_item(CMD_NOTE_ON, 7'd38, 7'd127, 32'd0, 1'b1, took);
    // repeat on a held target
    push_item(CMD_NOTE_ON, 7'd37, 7'd5, 32'd1, 1'b0, took);
    push_item(CMD_TICK, 7'd0, 7'd0, 32'd20, 1'b1, took);
    push_item(CMD_TICK, 7'd0, 7'd0, 32'd21, 1'b1, took);
  endtask

  task automatic test_console_cymbals();
    bit took;
    settle_block();
    set_register(CFG_GENERIC_MODE, 16'h0000);
    push_item(CMD_NOTE_ON, 7'd45, 7'd10, 32'd100, 1'b0, took);
    push_item(CMD_NOTE_ON, 7'd51, 7'd99, 32'd101, 1'b0, took);
    push_item(CMD_TICK, 7'd0, 7'd0, 32'd105, 1'b1, took);
    push_item(CMD_NOTE_ON, 7'd42, 7'd127, 32'd106, 1'b0, took);
    push_item(CMD_NOTE_ON, 7'd36, 7'd0, 32'd106, 1'b0, took);
    push_item(CMD_NOTE_ON, 7'd44, 7'd1, 32'd106, 1'b0, took);
    push_item(CMD_TICK, 7'd0, 7'd0, 32'd110, 1'b1, took);
    push_item(CMD_TICK, 7'd0, 7'd0, 32'd1000, 1'b1, took);
  endtask

  task automatic test_eviction_and_wrap();
    bit took;
    settle_block();
    set_register(CFG_GENERIC_MODE, 16'hfffe | 16'h0001);
    set_register(CFG_HOLD_MS, 16'hffff);
    // equal stamps: lowest target goes first
    push_item(CMD_NOTE_ON, 7'd48, 7'd1, 32'hffff_ffff, 1'b0, took);
    push_item(CMD_NOTE_ON, 7'd41, 7'd2, 32'hffff_ffff, 1'b0, took);
    push_item(CMD_NOTE_ON, 7'd49, 7'd3, 32'hffff_ffff, 1'b0, took);
    push_item(CMD_TICK, 7'd0, 7'd0, 32'h0000_fffe, 1'b1, took);
    push_item(CMD_TICK, 7'd0, 7'd0, 32'h0000_ffff, 1'b1, took);
  endtask

  task automatic run_random_phase(input logic mode, input logic [HOLD_W-1:0] hold,
                                  input int goal, input bit steady);
    int          done;
    int          pick;
    int          span;
    bit          took;
    logic [31:0] now_ms;
    logic [14:0] junk;
    settle_block();
    junk = 15'($urandom);
    set_register(CFG_GENERIC_MODE, {junk, mode});
    set_register(CFG_HOLD_MS, hold);
    calm = steady;
    span = int'(hold);
    now_ms = $urandom;
    done = 0;
    while (done < goal) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) now_ms = $urandom;
      else if ($urandom_range(0, 99) < 70) now_ms += $urandom_range(0, span / 4 + 1);
      else now_ms += $urandom_range(0, 2 * span + 2);
      if (pick < 6) begin
        push_item(1'($urandom_range(0, 1)), NOTE_W'($urandom_range(0, 127)),
                  VEL_W'($urandom_range(0, 127)), now_ms, 1'($urandom_range(0, 1)),
                  took);
      end else if (pick < 58) begin
        push_item(CMD_NOTE_ON, NOTE_W'(drum_notes[$urandom_range(0, 28)]),
                  VEL_W'($urandom_range(0, 127)), now_ms, 1'($urandom_range(0, 1)),
                  took);
      end else begin
        push_item(CMD_TICK, NOTE_W'($urandom_range(0, 127)),
                  VEL_W'($urandom_range(0, 127)), now_ms,
                  $urandom_range(0, 99) < 92, took);
      end
      if (took) done++;
    end
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(1'b1, HOLD_RESET, 80, 1'b0);
    run_random_phase(1'b0, 16'd0, 60, 1'b0);
    run_random_phase(1'b0, 16'hffff, 70, 1'b0);
    run_random_phase(1'b1, HOLD_W'($urandom_range(1, 200)), 70, 1'b0);
    run_random_phase(1'b0, HOLD_RESET, 90, 1'b1);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_console_cymbals();
    test_eviction_and_wrap();
    test_random_traffic();
    settle_block();
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
